// ----- sv/crdg_pkg.sv -----
// camera ray direction generator: shared types and constants
// used by every module of the block, no dependencies
`timescale 1ns / 1ps

package crdg_pkg;

   localparam int SCREEN_COLS_DEF = 1024;
   localparam int SCREEN_ROWS_DEF = 768;

   // magnitude width after the common right shift, and derived widths
   localparam int MAG_W  = 31;
   localparam int SUM_W  = 64;
   localparam int NORM_W = 32;
   localparam int QUO_W  = 15;
   localparam int SQRT_STAGES = NORM_W;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_SIN_YAW    = 3'd0;
   localparam logic [2:0] REG_COS_YAW    = 3'd1;
   localparam logic [2:0] REG_SIN_PITCH  = 3'd2;
   localparam logic [2:0] REG_COS_PITCH  = 3'd3;
   localparam logic [2:0] REG_VIEW_DEPTH = 3'd4;

   localparam logic [15:0] SIN_RESET   = 16'h0000;
   localparam logic [15:0] COS_RESET   = 16'h4000;
   localparam logic [15:0] DEPTH_RESET = 16'h1000;

   typedef struct packed {
      logic [15:0] sin_yaw;
      logic [15:0] cos_yaw;
      logic [15:0] sin_pitch;
      logic [15:0] cos_pitch;
      logic [15:0] view_depth;
   } cfg_type;

   // per-lane magnitudes and signs of the rotated vector
   typedef struct packed {
      logic [2:0]            neg;
      logic [2:0][MAG_W-1:0] mag;
   } vec_type;

endpackage

// ----- sv/crdg_csr.sv -----
// camera ray direction generator: configuration registers on an apb-style port
// depends on crdg_pkg
`timescale 1ns / 1ps

module crdg_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output crdg_pkg::cfg_type   cfg
);

   crdg_pkg::cfg_type cfg_ff;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sin_yaw    <= crdg_pkg::SIN_RESET;
         cfg_ff.cos_yaw    <= crdg_pkg::COS_RESET;
         cfg_ff.sin_pitch  <= crdg_pkg::SIN_RESET;
         cfg_ff.cos_pitch  <= crdg_pkg::COS_RESET;
         cfg_ff.view_depth <= crdg_pkg::DEPTH_RESET;
      end else if (wr_en) begin
         case (paddr[4:2])
            crdg_pkg::REG_SIN_YAW:    cfg_ff.sin_yaw    <= pwdata[15:0];
            crdg_pkg::REG_COS_YAW:    cfg_ff.cos_yaw    <= pwdata[15:0];
            crdg_pkg::REG_SIN_PITCH:  cfg_ff.sin_pitch  <= pwdata[15:0];
            crdg_pkg::REG_COS_PITCH:  cfg_ff.cos_pitch  <= pwdata[15:0];
            crdg_pkg::REG_VIEW_DEPTH: cfg_ff.view_depth <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         crdg_pkg::REG_SIN_YAW:    prdata = {16'h0000, cfg_ff.sin_yaw};
         crdg_pkg::REG_COS_YAW:    prdata = {16'h0000, cfg_ff.cos_yaw};
         crdg_pkg::REG_SIN_PITCH:  prdata = {16'h0000, cfg_ff.sin_pitch};
         crdg_pkg::REG_COS_PITCH:  prdata = {16'h0000, cfg_ff.cos_pitch};
         crdg_pkg::REG_VIEW_DEPTH: prdata = {16'h0000, cfg_ff.view_depth};
         default:                  prdata = 32'h0000_0000;
      endcase
   end

endmodule

// ----- sv/crdg_rotate.sv -----
// camera ray direction generator: centering, pitch and yaw rotation,
// magnitude scaling and sum of squares in nine register stages; depends on crdg_pkg
`timescale 1ns / 1ps

module crdg_rotate #(
   parameter int SCREEN_COLS = crdg_pkg::SCREEN_COLS_DEF,
   parameter int SCREEN_ROWS = crdg_pkg::SCREEN_ROWS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [11:0]                  pixel_col,
   input  logic [11:0]                  pixel_row,
   input  crdg_pkg::cfg_type            cfg,
   output logic                         out_valid,
   output logic [crdg_pkg::SUM_W-1:0]   out_sum,
   output crdg_pkg::vec_type            out_vec
);

   localparam int STAGES = 9;
   localparam int MW = crdg_pkg::MAG_W;
   localparam logic signed [13:0] HALF_COLS = 14'(SCREEN_COLS / 2);
   localparam logic signed [13:0] HALF_ROWS = 14'(SCREEN_ROWS / 2);
   localparam logic signed [14:0] COLS_S    = 15'(SCREEN_COLS);

   logic [STAGES-1:0] vld_ff;

   // stage 1: offsets and pitch products
   logic signed [13:0] x_in, y_in;
   logic signed [16:0] d_in;
   logic signed [13:0] s1_x_ff;
   logic signed [29:0] s1_ycp_ff, s1_ysp_ff;
   logic signed [32:0] s1_dcp_ff, s1_dsp_ff;
   // stage 2: pitch rotation
   logic signed [45:0] s2_py_ff, s2_pz_ff;
   logic signed [13:0] s2_x_ff;
   // stage 3: yaw products
   logic signed [29:0] s3_a_ff, s3_e_ff;
   logic signed [61:0] s3_b_ff, s3_c_ff;
   logic signed [45:0] s3_py_ff;
   // stage 4: rotated vector
   logic signed [61:0] s4_v_ff [3];
   // stage 5: magnitudes
   logic [60:0]        s5_mag_ff [3];
   logic [2:0]         s5_neg_ff;
   // stage 6: common shift
   logic [60:0]        or_w;
   logic [4:0]         sh_in;
   logic [60:0]        s6_mag_ff [3];
   logic [2:0]         s6_neg_ff;
   logic [4:0]         s6_sh_ff;
   // stage 7..9
   logic [MW-1:0]      s7_m_ff [3];
   logic [2:0]         s7_neg_ff;
   logic [2*MW-1:0]    s8_sq_ff [3];
   logic [MW-1:0]      s8_m_ff [3];
   logic [2:0]         s8_neg_ff;
   logic [crdg_pkg::SUM_W-1:0] s9_sum_ff;
   crdg_pkg::vec_type  s9_vec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   assign x_in = $signed({2'b00, pixel_col}) - HALF_COLS;
   assign y_in = HALF_ROWS - $signed({2'b00, pixel_row});
   assign d_in = $signed({1'b0, cfg.view_depth});

   assign or_w = s5_mag_ff[0] | s5_mag_ff[1] | s5_mag_ff[2];

   // smallest right shift that brings the largest magnitude below 2^31
   always_comb begin
      sh_in = '0;
      for (int i = MW; i < 61; i++) begin
         if (or_w[i]) begin
            sh_in = 5'(i - MW + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff   <= x_in;
         s1_ycp_ff <= 30'(y_in) * 30'($signed(cfg.cos_pitch));
         s1_ysp_ff <= 30'(y_in) * 30'($signed(cfg.sin_pitch));
         s1_dcp_ff <= 33'(d_in) * 33'($signed(cfg.cos_pitch));
         s1_dsp_ff <= 33'(d_in) * 33'($signed(cfg.sin_pitch));

         s2_x_ff  <= s1_x_ff;
         s2_py_ff <= (46'(s1_ycp_ff) <<< 12) - 46'(s1_dsp_ff) * 46'(COLS_S);
         s2_pz_ff <= 46'(s1_dcp_ff) * 46'(COLS_S) + (46'(s1_ysp_ff) <<< 12);

         s3_a_ff  <= 30'(s2_x_ff) * 30'($signed(cfg.cos_yaw));
         s3_e_ff  <= 30'(s2_x_ff) * 30'($signed(cfg.sin_yaw));
         s3_b_ff  <= 62'(s2_pz_ff) * 62'($signed(cfg.sin_yaw));
         s3_c_ff  <= 62'(s2_pz_ff) * 62'($signed(cfg.cos_yaw));
         s3_py_ff <= s2_py_ff;

         // x offset carries 2^12 for the pixel scale and 2^14 for the pitch scale
         s4_v_ff[0] <= (62'(s3_a_ff) <<< 26) - s3_b_ff;
         s4_v_ff[1] <= 62'(s3_py_ff) <<< 14;
         s4_v_ff[2] <= s3_c_ff + (62'(s3_e_ff) <<< 26);

         for (int j = 0; j < 3; j++) begin
            s5_neg_ff[j] <= s4_v_ff[j][61];
            s5_mag_ff[j] <= s4_v_ff[j][61] ? 61'(-s4_v_ff[j]) : 61'(s4_v_ff[j]);
         end

         s6_mag_ff <= s5_mag_ff;
         s6_neg_ff <= s5_neg_ff;
         s6_sh_ff  <= sh_in;

         for (int j = 0; j < 3; j++) begin
            s7_m_ff[j] <= MW'(s6_mag_ff[j] >> s6_sh_ff);
         end
         s7_neg_ff <= s6_neg_ff;

         for (int j = 0; j < 3; j++) begin
            s8_sq_ff[j] <= (2*MW)'(s7_m_ff[j]) * (2*MW)'(s7_m_ff[j]);
         end
         s8_m_ff   <= s7_m_ff;
         s8_neg_ff <= s7_neg_ff;

         s9_sum_ff <= crdg_pkg::SUM_W'(s8_sq_ff[0]) + crdg_pkg::SUM_W'(s8_sq_ff[1])
                    + crdg_pkg::SUM_W'(s8_sq_ff[2]);
         s9_vec_ff.neg <= s8_neg_ff;
         for (int j = 0; j < 3; j++) begin
            s9_vec_ff.mag[j] <= s8_m_ff[j];
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_sum   = s9_sum_ff;
   assign out_vec   = s9_vec_ff;

endmodule

// ----- sv/crdg_isqrt.sv -----
// camera ray direction generator: pipelined integer square root, one root bit per stage
// depends on crdg_pkg
`timescale 1ns / 1ps

module crdg_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [crdg_pkg::SUM_W-1:0]    in_sum,
   input  crdg_pkg::vec_type             in_vec,
   output logic                          out_valid,
   output logic [crdg_pkg::NORM_W-1:0]   out_norm,
   output crdg_pkg::vec_type             out_vec
);

   localparam int N = crdg_pkg::SQRT_STAGES;
   localparam int W = crdg_pkg::SUM_W;

   logic [W-1:0]      rem_ff  [N];
   logic [W-1:0]      root_ff [N];
   crdg_pkg::vec_type vec_ff  [N];
   logic              vld_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
      logic [W-1:0]      rem_in, root_in, trial;
      crdg_pkg::vec_type vec_in;
      logic              vld_in;

      if (k == 0) begin : g_first
         assign rem_in  = in_sum;
         assign root_in = '0;
         assign vec_in  = in_vec;
         assign vld_in  = in_valid;
      end else begin : g_next
         assign rem_in  = rem_ff[k-1];
         assign root_in = root_ff[k-1];
         assign vec_in  = vec_ff[k-1];
         assign vld_in  = vld_ff[k-1];
      end

      assign trial = root_in + BIT;

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_in >= trial) begin
               rem_ff[k]  <= rem_in - trial;
               root_ff[k] <= (root_in >> 1) + BIT;
            end else begin
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in >> 1;
            end
            vec_ff[k] <= vec_in;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_in;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_norm  = crdg_pkg::NORM_W'(root_ff[N-1]);
   assign out_vec   = vec_ff[N-1];

endmodule

// ----- sv/crdg_div.sv -----
// camera ray direction generator: three-lane pipelined restoring divider,
// one quotient bit per stage, computes round(mag * 2^14 / norm); depends on crdg_pkg
`timescale 1ns / 1ps

module crdg_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [crdg_pkg::NORM_W-1:0]          in_norm,
   input  crdg_pkg::vec_type                    in_vec,
   output logic                                 out_valid,
   output logic [2:0][crdg_pkg::QUO_W-1:0]      out_quo,
   output logic [2:0]                           out_neg,
   output logic                                 out_zero
);

   localparam int Q  = crdg_pkg::QUO_W;
   localparam int NW = crdg_pkg::MAG_W + Q + 1;    // numerator width
   localparam int DW = crdg_pkg::NORM_W + 1;       // divisor width

   // prep stage: numerator mag*2^15 + norm, divisor 2*norm
   logic [NW-1:0] pr_num_ff [3];
   logic [DW-1:0] pr_den_ff;
   logic [2:0]    pr_neg_ff;
   logic          pr_zero_ff;
   logic          pr_vld_ff;

   logic [NW-1:0]       rem_ff  [Q][3];
   logic [2:0][Q-1:0]   quo_ff  [Q];
   logic [DW-1:0]       den_ff  [Q];
   logic [2:0]          neg_ff  [Q];
   logic                zero_ff [Q];
   logic                vld_ff  [Q];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            pr_num_ff[j] <= {in_vec.mag[j], {Q{1'b0}}} + NW'(in_norm);
         end
         pr_den_ff  <= {in_norm, 1'b0};
         pr_neg_ff  <= in_vec.neg;
         pr_zero_ff <= (in_norm == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_vld_ff <= 1'b0;
      end else if (en) begin
         pr_vld_ff <= in_valid;
      end
   end

   for (genvar k = 0; k < Q; k++) begin : g_stage
      localparam int B = Q - 1 - k;
      logic [NW-1:0]     rem_in [3];
      logic [2:0][Q-1:0] quo_in;
      logic [DW-1:0]     den_in;
      logic [2:0]        neg_in;
      logic              zero_in, vld_in;
      logic [NW:0]       den_sh;

      if (k == 0) begin : g_first
         assign rem_in  = pr_num_ff;
         assign quo_in  = '0;
         assign den_in  = pr_den_ff;
         assign neg_in  = pr_neg_ff;
         assign zero_in = pr_zero_ff;
         assign vld_in  = pr_vld_ff;
      end else begin : g_next
         assign rem_in  = rem_ff[k-1];
         assign quo_in  = quo_ff[k-1];
         assign den_in  = den_ff[k-1];
         assign neg_in  = neg_ff[k-1];
         assign zero_in = zero_ff[k-1];
         assign vld_in  = vld_ff[k-1];
      end

      assign den_sh = (NW+1)'(den_in) << B;

      always_ff @(posedge clock) begin
         if (en) begin
            for (int j = 0; j < 3; j++) begin
               if ((NW+1)'(rem_in[j]) >= den_sh) begin
                  rem_ff[k][j] <= NW'((NW+1)'(rem_in[j]) - den_sh);
                  quo_ff[k][j] <= quo_in[j] | (Q'(1) << B);
               end else begin
                  rem_ff[k][j] <= rem_in[j];
                  quo_ff[k][j] <= quo_in[j];
               end
            end
            den_ff[k]  <= den_in;
            neg_ff[k]  <= neg_in;
            zero_ff[k] <= zero_in;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_in;
         end
      end
   end

   assign out_valid = vld_ff[Q-1];
   assign out_quo   = quo_ff[Q-1];
   assign out_neg   = neg_ff[Q-1];
   assign out_zero  = zero_ff[Q-1];

endmodule

// ----- sv/camera_ray_direction_generator_top.sv -----
// camera ray direction generator: top level, registers, rotation, square root,
// divider and output register; depends on crdg_pkg, crdg_csr, crdg_rotate,
// crdg_isqrt and crdg_div
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_pixel_col, req_pixel_row
//   rsp      out        rsp_valid/rsp_stall  rsp_dir_x, rsp_dir_y, rsp_dir_z
//   csr      in/out     psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// one item enters per cycle while the pipeline is not stalled; the path runs through 9 rotation stages, 32 square
// root stages (one root bit each), a divider setup stage, 15 divider stages
// (one quotient bit each) and the output register.
// reset is synchronous and clears only the valid bits and the registers.
// a stall on rsp freezes the whole pipeline, so req_stall follows it while an
// item waits in the output register.
`timescale 1ns / 1ps

module camera_ray_direction_generator_top #(
   parameter int SCREEN_COLS = crdg_pkg::SCREEN_COLS_DEF,
   parameter int SCREEN_ROWS = crdg_pkg::SCREEN_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_pixel_col,
   input  logic [11:0] req_pixel_row,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_dir_x,
   output logic [15:0] rsp_dir_y,
   output logic [15:0] rsp_dir_z,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int Q = crdg_pkg::QUO_W;

   crdg_pkg::cfg_type cfg;
   logic              en;

   logic                          rot_valid;
   logic [crdg_pkg::SUM_W-1:0]    rot_sum;
   crdg_pkg::vec_type             rot_vec;
   logic                          sq_valid;
   logic [crdg_pkg::NORM_W-1:0]   sq_norm;
   crdg_pkg::vec_type             sq_vec;
   logic                          dv_valid;
   logic [2:0][Q-1:0]             dv_quo;
   logic [2:0]                    dv_neg;
   logic                          dv_zero;

   logic        rsp_valid_ff;
   logic [15:0] dir_ff [3];
   logic [15:0] dir_in [3];

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   crdg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   crdg_rotate #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS)
   ) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .pixel_col (req_pixel_col),
      .pixel_row (req_pixel_row),
      .cfg       (cfg),
      .out_valid (rot_valid),
      .out_sum   (rot_sum),
      .out_vec   (rot_vec)
   );

   crdg_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rot_valid),
      .in_sum    (rot_sum),
      .in_vec    (rot_vec),
      .out_valid (sq_valid),
      .out_norm  (sq_norm),
      .out_vec   (sq_vec)
   );

   crdg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_norm   (sq_norm),
      .in_vec    (sq_vec),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_neg   (dv_neg),
      .out_zero  (dv_zero)
   );

   // zero vector gives a zero direction
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         if (dv_zero) begin
            dir_in[j] = '0;
         end else if (dv_neg[j]) begin
            dir_in[j] = 16'(-{1'b0, dv_quo[j]});
         end else begin
            dir_in[j] = {1'b0, dv_quo[j]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dir_ff <= dir_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dir_x = dir_ff[0];
   assign rsp_dir_y = dir_ff[1];
   assign rsp_dir_z = dir_ff[2];

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_dir_x) >= -16384 && $signed(rsp_dir_x) <= 16384
                  && $signed(rsp_dir_y) >= -16384 && $signed(rsp_dir_y) <= 16384
                  && $signed(rsp_dir_z) >= -16384 && $signed(rsp_dir_z) <= 16384))
      else $error("direction component outside unit range");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ----- tb/sv/camera_ray_direction_generator_top_tb.sv -----
// testbench for camera_ray_direction_generator_top: pixels in, unit ray directions out,
// compared against an in-bench integer predictor; registers set over the csr port
// depends on crdg_pkg and the block's rtl
`timescale 1ns / 1ps

module camera_ray_direction_generator_top_tb;

   localparam int COLS = crdg_pkg::SCREEN_COLS_DEF;
   localparam int ROWS = crdg_pkg::SCREEN_ROWS_DEF;
   localparam int DRAIN_CYCLES = 70;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic [11:0] col;
      logic [11:0] row;
   } pixel_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
   } dir_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [11:0] req_pixel_col;
   logic [11:0] req_pixel_row;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_dir_x;
   logic [15:0] rsp_dir_y;
   logic [15:0] rsp_dir_z;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   camera_ray_direction_generator_top uut (.*);

   // predictor copy of the registers
   logic signed [15:0] m_sin_yaw, m_cos_yaw, m_sin_pitch, m_cos_pitch;
   logic [15:0]        m_view_depth;

   pixel_type pixel_queue[$];
   dir_type   expected_dirs[$];
   int     error_count;
   int     send_idle_pct;
   int     stall_pct;
   int     hold_left;
   int     quiet_cycles;
   bit     req_taken;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic dir_type ray_direction(logic [11:0] col, logic [11:0] row);
      longint x, y, z, py, pz;
      longint v[3];
      longint unsigned m[3];
      longint unsigned mx, sum, rem, root, b, q;
      int sh;
      dir_type d;
      x = (longint'(col) - COLS / 2) * 4096;
      y = (ROWS / 2 - longint'(row)) * 4096;
      z = longint'(m_view_depth) * COLS;
      py = y * longint'(m_cos_pitch) - z * longint'(m_sin_pitch);
      pz = z * longint'(m_cos_pitch) + y * longint'(m_sin_pitch);
      v[0] = x * longint'(m_cos_yaw) * 16384 - pz * longint'(m_sin_yaw);
      v[1] = py * 16384;
      v[2] = pz * longint'(m_cos_yaw) + x * longint'(m_sin_yaw) * 16384;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
         if (m[i] > mx) mx = m[i];
      end
      sh = 0;
      while ((mx >> sh) >= 64'h8000_0000) sh++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = m[i] >> sh;
         sum += m[i] * m[i];
      end
      // bitwise integer square root
      rem = sum;
      root = 0;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem = rem - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      for (int i = 0; i < 3; i++) begin
         q = (root == 0) ? 0 : (m[i] * 32768 + root) / (2 * root);
         if (v[i] < 0) q = -q;
         case (i)
            0: d.x = q[15:0];
            1: d.y = q[15:0];
            default: d.z = q[15:0];
         endcase
      end
      return d;
   endfunction

   // driver
   always @(negedge clock) begin
      pixel_type p;
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               p = pixel_queue.pop_front();
               req_valid <= 1'b1;
               req_pixel_col <= p.col;
               req_pixel_row <= p.row;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      dir_type e;
      dir_type got;
      req_taken = req_valid && !req_stall && !reset;
      if (req_taken) expected_dirs.push_back(ray_direction(req_pixel_col, req_pixel_row));
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_dir_x, rsp_dir_y, rsp_dir_z};
         if (expected_dirs.size() == 0) begin
            $display("%0t: unexpected ray item %h", $time, got);
            error_count++;
         end else begin
            e = expected_dirs.pop_front();
            if (got.x !== e.x) begin
               $display("%0t: dir_x expected %h actual %h", $time, e.x, got.x);
               error_count++;
            end
            if (got.y !== e.y) begin
               $display("%0t: dir_y expected %h actual %h", $time, e.y, got.y);
               error_count++;
            end
            if (got.z !== e.z) begin
               $display("%0t: dir_z expected %h actual %h", $time, e.z, got.z);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[camera_ray_direction_generator_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [15:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= {16'h0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         crdg_pkg::REG_SIN_YAW:    m_sin_yaw = value;
         crdg_pkg::REG_COS_YAW:    m_cos_yaw = value;
         crdg_pkg::REG_SIN_PITCH:  m_sin_pitch = value;
         crdg_pkg::REG_COS_PITCH:  m_cos_pitch = value;
         crdg_pkg::REG_VIEW_DEPTH: m_view_depth = value;
         default: ;
      endcase
   endtask

   task automatic set_view(logic [15:0] sy, logic [15:0] cy, logic [15:0] sp,
                           logic [15:0] cp, logic [15:0] vd);
      csr_write(crdg_pkg::REG_SIN_YAW, sy);
      csr_write(crdg_pkg::REG_COS_YAW, cy);
      csr_write(crdg_pkg::REG_SIN_PITCH, sp);
      csr_write(crdg_pkg::REG_COS_PITCH, cp);
      csr_write(crdg_pkg::REG_VIEW_DEPTH, vd);
   endtask

   task automatic drain();
      @(negedge clock);
      while (pixel_queue.size() != 0 || expected_dirs.size() != 0 || req_valid)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic push_random(int n);
      pixel_type p;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 7) begin
            p.col = 12'($urandom_range(COLS - 1));
            p.row = 12'($urandom_range(ROWS - 1));
         end else begin
            p.col = 12'($urandom_range(4095));
            p.row = 12'($urandom_range(4095));
         end
         pixel_queue.push_back(p);
      end
   endtask

   function automatic logic [15:0] rand_trig();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel == 0) return 16'h8000;
      if (sel == 1) return 16'h7fff;
      if (sel < 5) return 16'($urandom_range(65535));
      return 16'(int'($urandom_range(32768)) - 16384);
   endfunction

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_col = '0;
      req_pixel_row = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      error_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_left = 0;
      quiet_cycles = 0;
      req_taken = 1'b0;
      m_sin_yaw = crdg_pkg::SIN_RESET;
      m_cos_yaw = crdg_pkg::COS_RESET;
      m_sin_pitch = crdg_pkg::SIN_RESET;
      m_cos_pitch = crdg_pkg::COS_RESET;
      m_view_depth = crdg_pkg::DEPTH_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset view, corners, center, off-screen pixels
      pixel_queue.push_back('{12'd0, 12'd0});
      pixel_queue.push_back('{12'd4095, 12'd4095});
      pixel_queue.push_back('{12'd0, 12'd4095});
      pixel_queue.push_back('{12'd4095, 12'd0});
      pixel_queue.push_back('{12'(COLS / 2), 12'(ROWS / 2)});
      pixel_queue.push_back('{12'(COLS - 1), 12'(ROWS - 1)});
      pixel_queue.push_back('{12'hAAA, 12'h555});
      pixel_queue.push_back('{12'h555, 12'hAAA});
      drain();

      // zero view depth: center pixel gives a zero vector
      set_view(16'h0000, 16'h4000, 16'h0000, 16'h4000, 16'h0000);
      pixel_queue.push_back('{12'(COLS / 2), 12'(ROWS / 2)});
      pixel_queue.push_back('{12'(COLS / 2 + 1), 12'(ROWS / 2)});
      pixel_queue.push_back('{12'd0, 12'(ROWS / 2)});
      drain();

      // extreme and off-circle trig values, widest depth
      set_view(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff);
      pixel_queue.push_back('{12'd0, 12'd0});
      pixel_queue.push_back('{12'd4095, 12'd4095});
      pixel_queue.push_back('{12'(COLS / 2), 12'(ROWS / 2)});
      pixel_queue.push_back('{12'd4095, 12'd0});
      drain();
      set_view(16'h4000, 16'h0000, 16'hc000, 16'h0000, 16'h0001);
      pixel_queue.push_back('{12'd0, 12'd4095});
      pixel_queue.push_back('{12'(COLS / 2), 12'(ROWS / 2)});
      pixel_queue.push_back('{12'd1023, 12'd767});
      drain();

      // random phases with different idle mixes
      for (int ph = 0; ph < 6; ph++) begin
         set_view(rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                  (ph == 2) ? 16'hffff : 16'($urandom_range(65535)));
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 46; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 46; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
         endcase
         if (ph == 4) begin
            // long receiver hold so the pipeline fills and stalls its input
            send_idle_pct = 0;
            stall_pct = 0;
            @(posedge clock);
            hold_left = 300;
         end
         push_random(150);
         drain();
      end
      send_idle_pct = 0;
      stall_pct = 0;
      drain();

      if (expected_dirs.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("[camera_ray_direction_generator_top] OK");
      end else begin
         $display("[camera_ray_direction_generator_top] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/crdg_pkg.sv
sv/crdg_csr.sv
sv/crdg_rotate.sv
sv/crdg_isqrt.sv
sv/crdg_div.sv
sv/camera_ray_direction_generator_top.sv
tb/sv/camera_ray_direction_generator_top_tb.sv
